>>> rtl/vds_pkg.sv
// shared types and constants of the vm data stack
package vds_pkg;

  localparam int unsigned DEPTH_DEF = 1024;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_STORE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADINDEX  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [9:0]         slot_index;
    logic signed [31:0] word_in;
  } item_t;

  typedef struct packed {
    logic signed [31:0] word_out;
    status_t            status;
    logic [10:0]        depth_now;
  } result_t;

  typedef struct packed {
    logic    rd;
    status_t status;
  } op_res_t;

endpackage

>>> rtl/vm_data_stack_indexed_top.sv
// top level of the vm data stack with indexed load and store
// the result strobe is registered and comes in the cycle after start is taken
// throughput: one item per cycle, busy stays low
// the single memory port does at most one access per item at the accept edge
// reset clears the fill count and the done strobe; the word store is not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
module vm_data_stack_indexed_top #(
  parameter int unsigned DEPTH = vds_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  vds_pkg::item_t   item,
  output logic             done,
  output vds_pkg::result_t result
);
  import vds_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = CW + 11;

  logic          accept;
  logic          we;
  logic          re;
  logic [AW-1:0] addr;
  logic [31:0]   wdata;
  logic [31:0]   rdata;
  op_res_t       res;
  logic [CW-1:0] fill_next;
  logic [DW-1:0] depth_x;

  logic          rd;
  status_t       status;
  logic [10:0]   depth_now;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign depth_x = DW'(fill_next);

  vds_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .we        (we),
    .re        (re),
    .addr      (addr),
    .wdata     (wdata),
    .res       (res),
    .fill_next (fill_next)
  );

  vds_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .re    (re),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd        <= res.rd;
      status    <= res.status;
      depth_now <= depth_x[10:0];
    end
  end

  assign result.word_out  = rd ? rdata : '0;
  assign result.status    = status;
  assign result.depth_now = depth_now;

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result without an accepted beat");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.word_out == '0))
    else $error("nonzero data on an error result");

endmodule

>>> rtl/vds_mem.sv
// word store with one write port and one registered read port
module vds_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [AW-1:0]     addr,
  input  logic [31:0]       wdata,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/vds_ctrl.sv
// command decode, bounds checks and fill count
module vds_ctrl #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned CW    = 11
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  vds_pkg::item_t  item,
  output logic            we,
  output logic            re,
  output logic [AW-1:0]   addr,
  output logic [31:0]     wdata,
  output vds_pkg::op_res_t res,
  output logic [CW-1:0]   fill_next
);
  import vds_pkg::*;

  localparam int unsigned XW = (CW > 10) ? CW : 10;

  logic [CW-1:0] fill;
  logic [CW-1:0] fill_dec;
  logic [CW-1:0] fill_inc;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] fill_x;
  logic          full;
  logic          empty;
  logic          idx_ok;

  assign fill_dec = fill - CW'(1);
  assign fill_inc = fill + CW'(1);
  assign idx_x    = XW'(item.slot_index);
  assign fill_x   = XW'(fill);
  assign full     = (fill == CW'(DEPTH));
  assign empty    = (fill == '0);
  assign idx_ok   = (idx_x < fill_x);
  assign wdata    = item.word_in;

  always_comb begin
    we         = 1'b0;
    re         = 1'b0;
    addr       = fill[AW-1:0];
    fill_next  = fill;
    res.rd     = 1'b0;
    res.status = ST_OK;
    case (item.cmd)
      CMD_PUSH: begin
        if (full) begin
          res.status = ST_OVERFLOW;
        end else begin
          we        = 1'b1;
          fill_next = fill_inc;
        end
      end
      CMD_POP: begin
        if (empty) begin
          res.status = ST_UNDERFLOW;
        end else begin
          re        = 1'b1;
          res.rd    = 1'b1;
          addr      = fill_dec[AW-1:0];
          fill_next = fill_dec;
        end
      end
      CMD_LOAD: begin
        addr = idx_x[AW-1:0];
        if (idx_ok) begin
          re     = 1'b1;
          res.rd = 1'b1;
        end else begin
          res.status = ST_BADINDEX;
        end
      end
      CMD_STORE: begin
        addr = idx_x[AW-1:0];
        if (idx_ok) begin
          we = 1'b1;
        end else begin
          res.status = ST_BADINDEX;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    if (!accept) begin
      we        = 1'b0;
      re        = 1'b0;
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && item.cmd == CMD_PUSH && !full) |=> (fill == $past(fill) + CW'(1)))
    else $error("push did not grow the stack");

  a_no_access_on_error: assert property (@(posedge clk) disable iff (rst)
    (res.status != ST_OK) |-> (!we && !re && fill_next == fill))
    else $error("store touched on an error");

endmodule

>>> test/tb_vm_data_stack_indexed_top.sv
// testbench for the vm data stack: directed and random push, pop, load and store against a local model
`timescale 1ns / 1ps

module tb_vm_data_stack_indexed_top;
  import vds_pkg::*;

  localparam int unsigned DUT_DEPTH = DEPTH_DEF;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item  = '0;
  logic    done;
  result_t result;

  logic [31:0] mirror_words [DUT_DEPTH];
  int unsigned mirror_fill = 0;
  result_t     expected_results [$];
  int unsigned mismatch_count = 0;
  bit          no_gaps = 1'b0;

  vm_data_stack_indexed_top #(
    .DEPTH(DUT_DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic result_t stack_apply(input item_t it);
    result_t r;
    r.word_out = '0;
    r.status   = ST_OK;
    case (it.cmd)
      CMD_PUSH: begin
        if (mirror_fill >= DUT_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          mirror_words[mirror_fill] = it.word_in;
          mirror_fill++;
        end
      end
      CMD_POP: begin
        if (mirror_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          mirror_fill--;
          r.word_out = mirror_words[mirror_fill];
        end
      end
      CMD_LOAD: begin
        if (it.slot_index >= mirror_fill || it.slot_index >= DUT_DEPTH) begin
          r.status = ST_BADINDEX;
        end else begin
          r.word_out = mirror_words[it.slot_index];
        end
      end
      default: begin
        if (it.slot_index >= mirror_fill || it.slot_index >= DUT_DEPTH) begin
          r.status = ST_BADINDEX;
        end else begin
          mirror_words[it.slot_index] = it.word_in;
        end
      end
    endcase
    r.depth_now = mirror_fill[10:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual %h", $time, result);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.word_out !== want.word_out) begin
          $display("%0t: word_out expected %h, actual %h", $time, want.word_out,
                   result.word_out);
          mismatch_count++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status,
                   result.status);
          mismatch_count++;
        end
        if (result.depth_now !== want.depth_now) begin
          $display("%0t: depth_now expected %0d, actual %0d", $time, want.depth_now,
                   result.depth_now);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_beat(input item_t it);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) begin
      no_gaps = ~no_gaps;
    end
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(stack_apply(it));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic item_t make_beat(input cmd_t c, input int unsigned idx,
                                      input logic [31:0] w);
    item_t it;
    it.cmd        = c;
    it.slot_index = 10'(idx);
    it.word_in    = w;
    return it;
  endfunction

  function automatic item_t random_item(input int unsigned push_pct,
                                        input int unsigned pop_pct,
                                        input int unsigned load_pct);
    item_t       it;
    int unsigned roll;
    roll       = $urandom_range(0, 99);
    it.word_in = $urandom();
    if (roll < push_pct) begin
      it.cmd = CMD_PUSH;
    end else if (roll < push_pct + pop_pct) begin
      it.cmd = CMD_POP;
    end else if (roll < push_pct + pop_pct + load_pct) begin
      it.cmd = CMD_LOAD;
    end else begin
      it.cmd = CMD_STORE;
    end
    roll = $urandom_range(0, 9);
    if (mirror_fill != 0 && roll < 7) begin
      it.slot_index = 10'($urandom_range(0, mirror_fill - 1));
    end else if (roll == 7) begin
      it.slot_index = mirror_fill[9:0];
    end else begin
      it.slot_index = 10'($urandom());
    end
    return it;
  endfunction

  task automatic test_empty_stack();
    send_beat(make_beat(CMD_POP, 0, 32'hdead_beef));
    send_beat(make_beat(CMD_LOAD, 0, 32'h0));
    send_beat(make_beat(CMD_STORE, 0, 32'h1234_5678));
    send_beat(make_beat(CMD_LOAD, 1023, 32'hffff_ffff));
  endtask

  task automatic test_word_extremes();
    send_beat(make_beat(CMD_PUSH, 1023, 32'h8000_0000));
    send_beat(make_beat(CMD_PUSH, 0, 32'h7fff_ffff));
    send_beat(make_beat(CMD_PUSH, 0, 32'h0000_0000));
    send_beat(make_beat(CMD_PUSH, 0, 32'hffff_ffff));
    send_beat(make_beat(CMD_LOAD, 0, 32'h0));
    send_beat(make_beat(CMD_LOAD, 3, 32'h0));
    send_beat(make_beat(CMD_LOAD, 4, 32'h0));
    send_beat(make_beat(CMD_STORE, 1, 32'h5555_5555));
    send_beat(make_beat(CMD_STORE, 4, 32'haaaa_aaaa));
    send_beat(make_beat(CMD_STORE, 1023, 32'haaaa_aaaa));
    send_beat(make_beat(CMD_LOAD, 1, 32'h0));
    repeat (4) send_beat(make_beat(CMD_POP, 0, 32'h0));
    send_beat(make_beat(CMD_POP, 0, 32'h0));
  endtask

  task automatic test_fill_and_overflow();
    while (mirror_fill < DUT_DEPTH) begin
      send_beat(random_item(96, 2, 1));
    end
    repeat (40) send_beat(random_item(50, 0, 25));
    send_beat(make_beat(CMD_LOAD, 1023, 32'h0));
    send_beat(make_beat(CMD_STORE, 1023, 32'hffff_ffff));
  endtask

  task automatic test_drain_and_underflow();
    while (mirror_fill != 0) begin
      send_beat(random_item(2, 96, 1));
    end
    repeat (40) send_beat(random_item(0, 50, 25));
  endtask

  task automatic test_mixed_traffic();
    repeat (200) send_beat(random_item(35, 30, 20));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_stack();
    test_word_extremes();
    wait_drained();
    test_fill_and_overflow();
    wait_drained();
    test_drain_and_underflow();
    wait_drained();
    test_mixed_traffic();
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
